// ----- hdl/ghash_accumulator_assert.svh -----
// Assertion macros for the checks in the top-level hash module.
`ifndef GHASH_ACCUMULATOR_ASSERT_SVH
`define GHASH_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GHA_ASSERT_IMPLY(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GHA_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- hdl/gha_pkg.sv -----
package gha_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int BLOCK_W     = 128;
	localparam int HALF_W      = 64;
	localparam int COUNT_W     = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int APB_ADDR_W  = 4;

	// Register index codes, taken from paddr[3].
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	// GCM reduction constant applied to the top byte after a right shift.
	localparam logic [7:0] GF_REDUCE_TOP = 8'hE1;

	typedef struct packed {
		logic [BLOCK_W-1:0] data;
		logic               absorb;
		logic               last;
	} item_t;

	typedef struct packed {
		item_t item;
		logic  valid;
	} head_t;

	typedef struct packed {
		logic pop;
		logic pop_last;
		logic acc_zero;
	} back_stat_t;

	// z = x * y in GF(2^128), GCM bit order (bit 127 of the vector is GCM bit 0).
	function automatic logic [BLOCK_W-1:0] gf_mul(input logic [BLOCK_W-1:0] x,
			input logic [BLOCK_W-1:0] y);
		logic [BLOCK_W-1:0] r;
		logic [BLOCK_W-1:0] v;
		logic               lsb;
		r = '0;
		v = y;
		for (int i = 0; i < BLOCK_W; i++) begin
			if (x[BLOCK_W-1-i]) begin
				r = r ^ v;
			end
			lsb = v[0];
			v = v >> 1;
			if (lsb) begin
				v[BLOCK_W-1 -: 8] = v[BLOCK_W-1 -: 8] ^ GF_REDUCE_TOP;
			end
		end
		return r;
	endfunction

endpackage

// ----- hdl/gha_front.sv -----
module gha_front #(
	parameter int DEPTH = gha_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         blk_valid,
	output logic                         blk_stall,
	input  logic [gha_pkg::HALF_W-1:0]   block_high,
	input  logic [gha_pkg::HALF_W-1:0]   block_low,
	input  logic [gha_pkg::COUNT_W-1:0]  valid_bytes,
	input  logic                         last_block,
	input  logic                         pop,
	output gha_pkg::head_t               head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	gha_pkg::item_t               mem_q [DEPTH];
	gha_pkg::item_t               item_in;
	logic [PTR_W-1:0]             wr_ptr_q;
	logic [PTR_W-1:0]             rd_ptr_q;
	logic [CNT_W-1:0]             count_q;
	logic [gha_pkg::COUNT_W-1:0]  count_sat;
	logic [gha_pkg::BLOCK_W-1:0]  mask;
	logic                         push;

	// Saturate oversize counts to a full block, then zero the trailing bytes.
	always_comb begin
		count_sat = (valid_bytes > gha_pkg::COUNT_W'(gha_pkg::BLOCK_BYTES))
			? gha_pkg::COUNT_W'(gha_pkg::BLOCK_BYTES) : valid_bytes;
		for (int i = 0; i < gha_pkg::BLOCK_BYTES; i++) begin
			mask[gha_pkg::BLOCK_W-1-8*i -: 8] =
				(gha_pkg::COUNT_W'(i) < count_sat) ? 8'hFF : 8'h00;
		end
		item_in.data   = {block_high, block_low} & mask;
		item_in.absorb = (count_sat != '0);
		item_in.last   = last_block;
	end

	assign blk_stall  = (count_q == CNT_FULL);
	assign push       = blk_valid && !blk_stall;
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/gha_back.sv -----
module gha_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gha_pkg::head_t              head,
	output logic                        pop,
	input  logic [gha_pkg::BLOCK_W-1:0] hash_key,
	output logic                        tag_valid,
	input  logic                        tag_stall,
	output logic [gha_pkg::HALF_W-1:0]  tag_high,
	output logic [gha_pkg::HALF_W-1:0]  tag_low,
	output gha_pkg::back_stat_t         stat
);

	logic [gha_pkg::BLOCK_W-1:0] acc_q;
	logic [gha_pkg::BLOCK_W-1:0] tag_q;
	logic                        tag_valid_q;
	logic [gha_pkg::BLOCK_W-1:0] y_mul;
	logic [gha_pkg::BLOCK_W-1:0] y_next;
	logic                        pop_last;

	// Hold a last item while the previous tag still waits.
	assign pop      = head.valid && (!head.item.last || !tag_valid_q || !tag_stall);
	assign pop_last = pop && head.item.last;
	assign y_mul    = gha_pkg::gf_mul(acc_q ^ head.item.data, hash_key);
	assign y_next   = head.item.absorb ? y_mul : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			tag_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= head.item.last ? '0 : y_next;
			end
			if (pop_last) begin
				tag_valid_q <= 1'b1;
			end else if (!tag_stall) begin
				tag_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_last) begin
			tag_q <= y_next;
		end
	end

	assign tag_valid     = tag_valid_q;
	assign tag_high      = tag_q[gha_pkg::BLOCK_W-1 -: gha_pkg::HALF_W];
	assign tag_low       = tag_q[gha_pkg::HALF_W-1:0];
	assign stat.pop      = pop;
	assign stat.pop_last = pop_last;
	assign stat.acc_zero = (acc_q == '0);

endmodule

// ----- hdl/ghash_accumulator.sv -----
// GHASH accumulator (GCM authentication hash).
// Key: write hash_key_high at byte address 0 and hash_key_low at 8 over the
// APB port (64-bit data, pready always high); reads return the key halves.
// Input channel (blk_valid / blk_stall): one 128-bit block per item, with a
// byte count of 1..16 (larger counts act as 16, zero absorbs nothing) and a
// last flag. Each absorbed block sets Y = (Y xor X) * H.
// Output channel (tag_valid / tag_stall): one tag per item marked last,
// after which Y returns to zero for the next message.
// Throughput: one item per cycle unless a last item waits on a stalled tag;
// the back end performs one full GF(2^128) multiply per cycle against the
// key register. An accepted item is registered in the queue, pops from its
// head, and a last item loads the tag register, which offers the tag.
// A small queue (QUEUE_DEPTH items) separates input from the multiplier;
// blk_stall rises only when it is full. While tag_stall holds a waiting tag,
// non-last items keep flowing; a last item waits at the queue head.
// Reset clears the key, Y, the queue and the output valid.
`include "ghash_accumulator_assert.svh"

module ghash_accumulator #(
	parameter int QUEUE_DEPTH = gha_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gha_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gha_pkg::HALF_W-1:0]     pwdata,
	output logic [gha_pkg::HALF_W-1:0]     prdata,
	output logic                           pready,
	input  logic                           blk_valid,
	output logic                           blk_stall,
	input  logic [gha_pkg::HALF_W-1:0]     block_high,
	input  logic [gha_pkg::HALF_W-1:0]     block_low,
	input  logic [gha_pkg::COUNT_W-1:0]    valid_bytes,
	input  logic                           last_block,
	output logic                           tag_valid,
	input  logic                           tag_stall,
	output logic [gha_pkg::HALF_W-1:0]     tag_high,
	output logic [gha_pkg::HALF_W-1:0]     tag_low
);

	logic [gha_pkg::HALF_W-1:0] key_high_q;
	logic [gha_pkg::HALF_W-1:0] key_low_q;
	logic                       cfg_write;
	logic                       reg_sel;
	logic                       pop;
	gha_pkg::head_t             head;
	gha_pkg::back_stat_t        back_stat;

	assign pready    = 1'b1;
	assign reg_sel   = paddr[3];
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (reg_sel == gha_pkg::REG_KEY_LOW) ? key_low_q : key_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_write) begin
			case (reg_sel)
				gha_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				gha_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
				default: ;
			endcase
		end
	end

	gha_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_valid  (blk_valid),
		.blk_stall  (blk_stall),
		.block_high (block_high),
		.block_low  (block_low),
		.valid_bytes(valid_bytes),
		.last_block (last_block),
		.pop        (pop),
		.head       (head)
	);

	gha_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.hash_key ({key_high_q, key_low_q}),
		.tag_valid(tag_valid),
		.tag_stall(tag_stall),
		.tag_high (tag_high),
		.tag_low  (tag_low),
		.stat     (back_stat)
	);

	`GHA_ASSERT_NEXT(a_push_fills_queue, clk, arst_n, blk_valid && !blk_stall, head.valid)
	`GHA_ASSERT_NEXT(a_last_raises_tag, clk, arst_n, back_stat.pop_last, tag_valid)
	`GHA_ASSERT_NEXT(a_last_clears_acc, clk, arst_n, back_stat.pop_last, back_stat.acc_zero)
	`GHA_ASSERT_IMPLY(a_pop_needs_item, clk, arst_n, back_stat.pop, head.valid)

endmodule

// ----- tb/ghash_accumulator_checker.sv -----
`timescale 1ns / 1ps
module ghash_accumulator_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [gha_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gha_pkg::HALF_W-1:0]     pwdata,
	input  logic                           blk_valid,
	input  logic                           blk_stall,
	input  logic [gha_pkg::HALF_W-1:0]     block_high,
	input  logic [gha_pkg::HALF_W-1:0]     block_low,
	input  logic [gha_pkg::COUNT_W-1:0]    valid_bytes,
	input  logic                           last_block,
	input  logic                           tag_valid,
	input  logic                           tag_stall,
	input  logic [gha_pkg::HALF_W-1:0]     tag_high,
	input  logic [gha_pkg::HALF_W-1:0]     tag_low,
	output int                             fail_count,
	output int                             tags_pending
);

	// x^128 + x^7 + x^2 + x + 1 in GCM bit order, folded into the top byte
	localparam logic [gha_pkg::BLOCK_W-1:0] GF_POLY_TOP = {8'hE1, 120'd0};

	logic [gha_pkg::BLOCK_W-1:0] hash_key;
	logic [gha_pkg::BLOCK_W-1:0] running_hash;
	logic [gha_pkg::BLOCK_W-1:0] expected_tags[$];

	task automatic report_mismatch(input string what,
			input logic [gha_pkg::HALF_W-1:0] want,
			input logic [gha_pkg::HALF_W-1:0] got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : predict_and_check
		logic [gha_pkg::BLOCK_W-1:0] x;
		logic [gha_pkg::BLOCK_W-1:0] v;
		logic [gha_pkg::BLOCK_W-1:0] prod;
		logic [gha_pkg::BLOCK_W-1:0] want;
		int unsigned                 nbytes;
		if (!arst_n) begin
			hash_key = '0;
			running_hash = '0;
			expected_tags.delete();
			fail_count = 0;
		end else begin
			if (tag_valid && !tag_stall) begin
				if (expected_tags.size() == 0) begin
					report_mismatch("unexpected tag_high", '0, tag_high);
				end else begin
					want = expected_tags.pop_front();
					if (tag_high !== want[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W]) begin
						report_mismatch("tag_high", want[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W],
							tag_high);
					end
					if (tag_low !== want[gha_pkg::HALF_W-1:0]) begin
						report_mismatch("tag_low", want[gha_pkg::HALF_W-1:0], tag_low);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == gha_pkg::REG_KEY_HIGH) begin
					hash_key[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W] = pwdata;
				end else begin
					hash_key[gha_pkg::HALF_W-1:0] = pwdata;
				end
			end
			if (blk_valid && !blk_stall) begin
				// oversize counts act as a full block
				nbytes = (valid_bytes > gha_pkg::BLOCK_BYTES) ? gha_pkg::BLOCK_BYTES
					: valid_bytes;
				if (nbytes != 0) begin
					x = running_hash ^ ({block_high, block_low} &
						({gha_pkg::BLOCK_W{1'b1}} << (8 * (gha_pkg::BLOCK_BYTES - nbytes))));
					v = hash_key;
					prod = '0;
					for (int k = gha_pkg::BLOCK_W - 1; k >= 0; k--) begin
						if (x[k]) begin
							prod = prod ^ v;
						end
						v = v[0] ? ((v >> 1) ^ GF_POLY_TOP) : (v >> 1);
					end
					running_hash = prod;
				end
				if (last_block) begin
					expected_tags.push_back(running_hash);
					running_hash = '0;
				end
			end
		end
		tags_pending = expected_tags.size();
	end

endmodule

// ----- tb/tb_ghash_accumulator.sv -----
`timescale 1ns / 1ps
module tb_ghash_accumulator;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int ITEM_TARGET  = 1150;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [gha_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [gha_pkg::HALF_W-1:0]     pwdata = '0;
	logic [gha_pkg::HALF_W-1:0]     prdata;
	logic                           pready;
	logic                           blk_valid = 1'b0;
	logic                           blk_stall;
	logic [gha_pkg::HALF_W-1:0]     block_high = '0;
	logic [gha_pkg::HALF_W-1:0]     block_low = '0;
	logic [gha_pkg::COUNT_W-1:0]    valid_bytes = '0;
	logic                           last_block = 1'b0;
	logic                           tag_valid;
	logic                           tag_stall = 1'b0;
	logic [gha_pkg::HALF_W-1:0]     tag_high;
	logic [gha_pkg::HALF_W-1:0]     tag_low;

	int fail_count;
	int tags_pending;
	int items_sent = 0;
	int gap_pct = 25;
	bit quiet = 1'b0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit stall_run = 1'b0;

	ghash_accumulator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.blk_valid  (blk_valid),
		.blk_stall  (blk_stall),
		.block_high (block_high),
		.block_low  (block_low),
		.valid_bytes(valid_bytes),
		.last_block (last_block),
		.tag_valid  (tag_valid),
		.tag_stall  (tag_stall),
		.tag_high   (tag_high),
		.tag_low    (tag_low)
	);

	ghash_accumulator_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.blk_valid   (blk_valid),
		.blk_stall   (blk_stall),
		.block_high  (block_high),
		.block_low   (block_low),
		.valid_bytes (valid_bytes),
		.last_block  (last_block),
		.tag_valid   (tag_valid),
		.tag_stall   (tag_stall),
		.tag_high    (tag_high),
		.tag_low     (tag_low),
		.fail_count  (fail_count),
		.tags_pending(tags_pending)
	);

	always #1 clk = ~clk;

	// alternate stall bursts with calm runs on the tag side
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_run = ($urandom_range(0, 99) < 30);
			stall_left = stall_run ? $urandom_range(1, 14) : $urandom_range(1, 40);
		end
		stall_left--;
		tag_stall <= stall_run && !quiet;
	end

	always @(posedge clk) begin
		if (!arst_n || (blk_valid && !blk_stall) || (tag_valid && !tag_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("ghash_accumulator test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [gha_pkg::HALF_W-1:0] rand_half();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Drop valid, wait for every tag, then let the queue empty.
	task automatic hold_off();
		@(negedge clk);
		blk_valid <= 1'b0;
		while (tags_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_key(input logic idx, input logic [gha_pkg::HALF_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_item(input logic [gha_pkg::HALF_W-1:0] bh,
			input logic [gha_pkg::HALF_W-1:0] bl,
			input logic [gha_pkg::COUNT_W-1:0] cnt, input logic last);
		int gap;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			blk_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		blk_valid <= 1'b1;
		block_high <= bh;
		block_low <= bl;
		valid_bytes <= cnt;
		last_block <= last;
		do @(posedge clk); while (blk_stall);
		items_sent++;
	endtask

	task automatic send_message();
		int                          n_blocks;
		logic [gha_pkg::COUNT_W-1:0] cnt;
		n_blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
		for (int b = 0; b < n_blocks - 1; b++) begin
			// mostly full blocks, now and then a skip, a short block or an oversize count
			case ($urandom_range(0, 11))
				0: cnt = '0;
				1: cnt = gha_pkg::COUNT_W'($urandom_range(17, 31));
				2: cnt = gha_pkg::COUNT_W'($urandom_range(1, 15));
				default: cnt = gha_pkg::COUNT_W'(gha_pkg::BLOCK_BYTES);
			endcase
			send_item(rand_half(), rand_half(), cnt, 1'b0);
			if (!quiet && $urandom_range(0, 199) == 0) begin
				hold_off();
				write_key($urandom_range(0, 1) ? gha_pkg::REG_KEY_LOW : gha_pkg::REG_KEY_HIGH,
					rand_half());
			end
		end
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'($urandom_range(0, 16)), 1'b1);
	endtask

	initial begin
		logic [gha_pkg::BLOCK_W-1:0] next_key;
		int                          phase_end;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// key is still zero after reset, so this tag is zero
		send_item('1, '1, gha_pkg::COUNT_W'(16), 1'b1);
		hold_off();
		write_key(gha_pkg::REG_KEY_HIGH, {$urandom, $urandom});
		write_key(gha_pkg::REG_KEY_LOW, {$urandom, $urandom});
		send_item('1, '1, gha_pkg::COUNT_W'(16), 1'b0);
		send_item('0, '0, gha_pkg::COUNT_W'(16), 1'b0);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(1), 1'b0);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(8), 1'b0);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(9), 1'b0);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(15), 1'b1);
		send_item('1, '1, gha_pkg::COUNT_W'(0), 1'b0);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(31), 1'b0);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(17), 1'b0);
		// tag from what is already absorbed, then an empty message
		send_item('1, '1, gha_pkg::COUNT_W'(0), 1'b1);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(0), 1'b1);
		// swap the key halfway through a message
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(16), 1'b0);
		hold_off();
		write_key(gha_pkg::REG_KEY_HIGH, '1);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(16), 1'b0);
		hold_off();
		write_key(gha_pkg::REG_KEY_LOW, '1);
		send_item('1, '1, gha_pkg::COUNT_W'(16), 1'b1);
		hold_off();
		write_key(gha_pkg::REG_KEY_HIGH, '0);
		write_key(gha_pkg::REG_KEY_LOW, 64'd1);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(16), 1'b0);
		send_item(rand_half(), rand_half(), gha_pkg::COUNT_W'(12), 1'b1);

		for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
			case (phase % 6)
				0: next_key = '1;
				1: next_key = '0;
				2: next_key = 128'd1;
				3: next_key = {1'b1, 127'd0};
				default: next_key = {rand_half(), rand_half()};
			endcase
			hold_off();
			write_key(gha_pkg::REG_KEY_HIGH, next_key[gha_pkg::BLOCK_W-1:gha_pkg::HALF_W]);
			write_key(gha_pkg::REG_KEY_LOW, next_key[gha_pkg::HALF_W-1:0]);
			gap_pct = (phase % 3 == 0) ? 0 : 25;
			quiet = (items_sent > ITEM_TARGET - 150);
			phase_end = items_sent + 100;
			while (items_sent < phase_end && items_sent < ITEM_TARGET) send_message();
		end

		hold_off();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && tags_pending == 0) begin
			$display("ghash_accumulator test passed");
		end else begin
			$display("ghash_accumulator test failed");
		end
		$finish;
	end

endmodule
